### rtl/posting_list_varint_delta_decoder_defines.svh
// assertion macros for the posting list varint delta decoder
`ifndef POSTING_LIST_VARINT_DELTA_DECODER_DEFINES_SVH
`define POSTING_LIST_VARINT_DELTA_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// checked outside reset
`define PLDD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pldd assertion failed");

// checked at every edge, reset included
`define PLDD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pldd assertion failed");

`else

`define PLDD_ASSERT(label, prop)
`define PLDD_ASSERT_ALWAYS(label, prop)

`endif

`endif

### rtl/pldd_pkg.sv
// shared types and constants of the posting list varint delta decoder
package pldd_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int OUT_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   localparam int NUM_FIELDS = 5;
   localparam int GROUP_BITS = 7;

   localparam logic [7:0] GROUP_MASK = 8'h7f;
   localparam logic [7:0] CONT_BIT = 8'h80;
   localparam logic [2:0] MAX_GROUPS = 3'd5;
   localparam logic [2:0] LAST_FIELD = 3'd4;
   localparam logic [2:0] VIDEO_FIELD = 3'd0;

   typedef enum logic {
      ACT_BEGIN = 1'b0,
      ACT_BYTE = 1'b1
   } action_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] video_number;
      logic [OUT_WIDTH-1:0] word_position;
      logic [OUT_WIDTH-1:0] time_start;
      logic [OUT_WIDTH-1:0] time_end;
      logic [OUT_WIDTH-1:0] byte_offset;
      logic last_entry;
   } entry_type;

endpackage

### rtl/pldd_core.sv
// varint assembly, delta accumulation and entry counting
module pldd_core #(
   parameter int VALUE_WIDTH = pldd_pkg::VALUE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  pldd_pkg::action_type action,
   input  logic [7:0] byte_value,
   input  logic [pldd_pkg::COUNT_WIDTH-1:0] entry_count,
   output logic emit,
   output pldd_pkg::entry_type entry
);
   import pldd_pkg::*;

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [2:0] gi_ff, gi_in;
   logic [2:0] fi_ff, fi_in;
   logic [VALUE_WIDTH-1:0] fields_ff [NUM_FIELDS];
   logic [VALUE_WIDTH-1:0] fields_in [NUM_FIELDS];
   logic [COUNT_WIDTH-1:0] left_ff, left_in;

   logic [6:0] grp;
   logic cont;
   logic [4:0] shamt;
   logic [VALUE_WIDTH+34:0] grp_wide;
   logic [VALUE_WIDTH-1:0] acc_or;
   logic [2:0] fsel;
   logic [VALUE_WIDTH-1:0] sum;
   logic [VALUE_WIDTH+OUT_WIDTH-1:0] ext [NUM_FIELDS];

   assign grp = 7'(byte_value & GROUP_MASK);
   assign cont = |(byte_value & CONT_BIT);
   assign shamt = 5'(32'(gi_ff) * GROUP_BITS);
   assign grp_wide = {{(VALUE_WIDTH + 28){1'b0}}, grp} << shamt;
   assign acc_or = (gi_ff < MAX_GROUPS) ? (acc_ff | grp_wide[VALUE_WIDTH-1:0]) : acc_ff;
   assign fsel = (fi_ff > LAST_FIELD) ? LAST_FIELD : fi_ff;
   assign sum = fields_ff[fsel] + acc_or;

   always_comb begin
      acc_in = acc_ff;
      gi_in = gi_ff;
      fi_in = fi_ff;
      fields_in = fields_ff;
      left_in = left_ff;
      emit = 1'b0;
      if (action == ACT_BEGIN) begin
         acc_in = '0;
         gi_in = '0;
         fi_in = '0;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            fields_in[i] = '0;
         end
         left_in = entry_count;
      end else if (left_ff != '0) begin
         if (cont) begin
            acc_in = acc_or;
            if (gi_ff < MAX_GROUPS) begin
               gi_in = gi_ff + 3'd1;
            end
         end else begin
            acc_in = '0;
            gi_in = '0;
            // a new video restarts the other running fields
            if (fsel == VIDEO_FIELD && acc_or != '0) begin
               for (int i = 1; i < NUM_FIELDS; i++) begin
                  fields_in[i] = '0;
               end
            end
            fields_in[fsel] = sum;
            if (fsel < LAST_FIELD) begin
               fi_in = fsel + 3'd1;
            end else begin
               fi_in = '0;
               left_in = left_ff - COUNT_WIDTH'(1);
               emit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
         ext[i] = {{OUT_WIDTH{1'b0}}, fields_in[i]};
      end
      entry.video_number = ext[0][OUT_WIDTH-1:0];
      entry.word_position = ext[1][OUT_WIDTH-1:0];
      entry.time_start = ext[2][OUT_WIDTH-1:0];
      entry.time_end = ext[3][OUT_WIDTH-1:0];
      entry.byte_offset = ext[4][OUT_WIDTH-1:0];
      entry.last_entry = (left_ff == COUNT_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         gi_ff <= '0;
         fi_ff <= '0;
         left_ff <= '0;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            fields_ff[i] <= '0;
         end
      end else if (step_en) begin
         acc_ff <= acc_in;
         gi_ff <= gi_in;
         fi_ff <= fi_in;
         left_ff <= left_in;
         fields_ff <= fields_in;
      end
   end

endmodule

### rtl/posting_list_varint_delta_decoder.sv
// top level of the posting list varint delta decoder
//
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_action, req_byte_value, req_entry_count
// rsp      out        rsp_valid/rsp_stall   rsp_video_number .. rsp_byte_offset, rsp_last_entry
//
// one item per cycle unless a stalled result holds one back: an item is held in
// the input register, then the core folds it into the varint and running sums
// and the result register catches a finished entry
// synchronous active high reset clears all decode state and both valids
// a stalled result only holds back an item that would finish another entry
`include "posting_list_varint_delta_decoder_defines.svh"

module posting_list_varint_delta_decoder #(
   parameter int VALUE_WIDTH = pldd_pkg::VALUE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic [7:0] req_byte_value,
   input  logic [pldd_pkg::COUNT_WIDTH-1:0] req_entry_count,
   // result channel
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [pldd_pkg::OUT_WIDTH-1:0] rsp_video_number,
   output logic [pldd_pkg::OUT_WIDTH-1:0] rsp_word_position,
   output logic [pldd_pkg::OUT_WIDTH-1:0] rsp_time_start,
   output logic [pldd_pkg::OUT_WIDTH-1:0] rsp_time_end,
   output logic [pldd_pkg::OUT_WIDTH-1:0] rsp_byte_offset,
   output logic rsp_last_entry
);
   import pldd_pkg::*;

   // input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_action_ff;
   logic [7:0] s1_byte_ff;
   logic [COUNT_WIDTH-1:0] s1_count_ff;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   entry_type rsp_entry_ff;

   logic req_take;
   logic slot_free;
   logic advance;
   logic core_emit;
   entry_type core_entry;

   assign req_take = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   // an item that finishes no entry always moves on
   assign advance = s1_valid_ff && (!core_emit || slot_free);
   assign req_stall = s1_valid_ff && !advance;

   assign s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (advance && core_emit) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   pldd_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step_en(advance),
      .action(action_type'(s1_action_ff)),
      .byte_value(s1_byte_ff),
      .entry_count(s1_count_ff),
      .emit(core_emit),
      .entry(core_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_action;
         s1_byte_ff <= req_byte_value;
         s1_count_ff <= req_entry_count;
      end
      if (advance && core_emit) begin
         rsp_entry_ff <= core_entry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_video_number = rsp_entry_ff.video_number;
   assign rsp_word_position = rsp_entry_ff.word_position;
   assign rsp_time_start = rsp_entry_ff.time_start;
   assign rsp_time_end = rsp_entry_ff.time_end;
   assign rsp_byte_offset = rsp_entry_ff.byte_offset;
   assign rsp_last_entry = rsp_entry_ff.last_entry;

   // a begin item never completes an entry
   `PLDD_ASSERT(a_begin_no_entry, (s1_valid_ff && s1_action_ff == ACT_BEGIN) |-> !core_emit)
   // an entry only completes on a byte that closes a varint
   `PLDD_ASSERT(a_entry_on_final_byte, core_emit |-> (s1_action_ff == ACT_BYTE && !s1_byte_ff[7]))
   // input side is held back only by a full, stalled result register
   `PLDD_ASSERT_ALWAYS(a_stall_cause, req_stall |-> (rsp_valid_ff && rsp_stall))

endmodule

### tb/posting_list_varint_delta_decoder_tb.sv
// self-checking testbench of the posting list varint delta decoder
`timescale 1ns / 100ps

module posting_list_varint_delta_decoder_tb;
   import pldd_pkg::*;

   // generous bound: every item waiting out the longest sender gap and result stall
   localparam int CYCLE_LIMIT = 400000;
   localparam int STREAM_ITEMS = 500;
   // settle time once the block owes nothing, with a margin
   localparam int SETTLE_CYCLES = 8;

   // running decode state plus the queue of entries still owed by the block
   class entry_scoreboard;
      logic [OUT_WIDTH-1:0] accum;
      logic [2:0] group_cnt;
      logic [2:0] field_sel;
      logic [OUT_WIDTH-1:0] sums [NUM_FIELDS];
      logic [COUNT_WIDTH-1:0] entries_left;
      entry_type pending_entries[$];
      int unsigned error_count;

      function new();
         accum = '0;
         group_cnt = '0;
         field_sel = VIDEO_FIELD;
         foreach (sums[i]) sums[i] = '0;
         entries_left = '0;
         error_count = 0;
      endfunction

      function int pending();
         return pending_entries.size();
      endfunction

      // fold one accepted item into the decode state, queue a finished entry
      function void note_item(action_type act, logic [7:0] data,
                              logic [COUNT_WIDTH-1:0] count);
         logic [63:0] group_bits;
         logic [OUT_WIDTH-1:0] diff;
         entry_type done;
         if (act == ACT_BEGIN) begin
            accum = '0;
            group_cnt = '0;
            field_sel = VIDEO_FIELD;
            foreach (sums[i]) sums[i] = '0;
            entries_left = count;
            return;
         end
         // count used up: byte is dropped
         if (entries_left == 0) return;
         // groups past the fifth are dropped, bits above the width too
         if (group_cnt < MAX_GROUPS) begin
            group_bits = 64'(data & GROUP_MASK) << (GROUP_BITS * group_cnt);
            accum |= group_bits[OUT_WIDTH-1:0];
         end
         if ((data & CONT_BIT) != 0) begin
            if (group_cnt < MAX_GROUPS) group_cnt++;
            return;
         end
         diff = accum;
         accum = '0;
         group_cnt = '0;
         // a new video restarts the other running fields
         if (field_sel == VIDEO_FIELD && diff != 0) begin
            for (int i = 1; i < NUM_FIELDS; i++) sums[i] = '0;
         end
         sums[field_sel] += diff;
         if (field_sel != LAST_FIELD) begin
            field_sel++;
            return;
         end
         field_sel = VIDEO_FIELD;
         entries_left--;
         done.video_number = sums[0];
         done.word_position = sums[1];
         done.time_start = sums[2];
         done.time_end = sums[3];
         done.byte_offset = sums[4];
         done.last_entry = (entries_left == 0);
         pending_entries.push_back(done);
      endfunction

      function void compare_field(string name, logic [OUT_WIDTH-1:0] want,
                                  logic [OUT_WIDTH-1:0] got);
         if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_entry(entry_type got);
         entry_type want;
         if (pending_entries.size() == 0) begin
            $error("entry with none expected: video_number %h", got.video_number);
            error_count++;
            return;
         end
         want = pending_entries.pop_front();
         compare_field("video_number", want.video_number, got.video_number);
         compare_field("word_position", want.word_position, got.word_position);
         compare_field("time_start", want.time_start, got.time_start);
         compare_field("time_end", want.time_end, got.time_end);
         compare_field("byte_offset", want.byte_offset, got.byte_offset);
         compare_field("last_entry", OUT_WIDTH'(want.last_entry),
                       OUT_WIDTH'(got.last_entry));
      endfunction

      function void flush_leftover();
         while (pending_entries.size() != 0) begin
            $error("entry never delivered: video_number %h",
                   pending_entries.pop_front().video_number);
            error_count++;
         end
      endfunction
   endclass

   // all block inputs start at known values
   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   action_type req_action = ACT_BYTE;
   logic [7:0] req_byte_value = '0;
   logic [COUNT_WIDTH-1:0] req_entry_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_WIDTH-1:0] rsp_video_number;
   logic [OUT_WIDTH-1:0] rsp_word_position;
   logic [OUT_WIDTH-1:0] rsp_time_start;
   logic [OUT_WIDTH-1:0] rsp_time_end;
   logic [OUT_WIDTH-1:0] rsp_byte_offset;
   logic rsp_last_entry;
   entry_type rsp_entry;

   entry_scoreboard entry_sb = new();

   // sender burst shaping
   int burst_left = 0;
   int idle_style = 1;
   int stream_items = 0;
   int cycle_count;

   // receiver stall pattern
   int stall_mode = 0;
   int stall_phase_left = 0;
   int stall_run = 0;

   posting_list_varint_delta_decoder u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_byte_value(req_byte_value),
      .req_entry_count(req_entry_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_video_number(rsp_video_number),
      .rsp_word_position(rsp_word_position),
      .rsp_time_start(rsp_time_start),
      .rsp_time_end(rsp_time_end),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_last_entry(rsp_last_entry)
   );

   assign rsp_entry = {rsp_video_number, rsp_word_position, rsp_time_start,
                       rsp_time_end, rsp_byte_offset, rsp_last_entry};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // both handshakes sampled at the edge, values are the pre-edge ones
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            entry_sb.note_item(req_action, req_byte_value, req_entry_count);
         if (rsp_valid && !rsp_stall)
            entry_sb.check_entry(rsp_entry);
      end
   end

   // receiver: phases of no stall, scattered stalls and long stall runs
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_phase_left <= $urandom_range(50, 300);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run == 0) begin
               rsp_stall <= ~rsp_stall;
               stall_run <= rsp_stall ? $urandom_range(1, 4) : $urandom_range(1, 20);
            end else begin
               stall_run <= stall_run - 1;
            end
         end
      endcase
   end

   // present one item and hold it until taken; gaps come between bursts
   task automatic send_item(action_type act, logic [7:0] data,
                            logic [COUNT_WIDTH-1:0] count);
      int gap;
      if (burst_left == 0) begin
         if (idle_style != 0) begin
            gap = $urandom_range(1, (idle_style == 1) ? 3 : 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 7) == 0) idle_style = $urandom_range(0, 2);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_action <= act;
      req_byte_value <= data;
      req_entry_count <= count;
      do @(posedge clock); while (req_stall);
   endtask

   // begin item with a random byte in the unused field
   task automatic send_begin(logic [COUNT_WIDTH-1:0] count);
      send_item(ACT_BEGIN, 8'($urandom()), count);
      stream_items++;
   endtask

   // fill: 0 all-zero groups, 1 all-ones groups, else random groups
   task automatic send_varint(int groups, int fill);
      logic [6:0] data;
      for (int g = 0; g < groups; g++) begin
         case (fill)
            0: data = '0;
            1: data = '1;
            default: data = 7'($urandom());
         endcase
         send_item(ACT_BYTE, {(g != groups - 1), data}, $urandom());
         stream_items++;
      end
   endtask

   // mostly short varints, some full length, a few overlong
   function automatic int pick_groups();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 1;
      if (r < 70) return $urandom_range(2, 4);
      if (r < 90) return 5;
      return $urandom_range(6, 8);
   endfunction

   function automatic int pick_fill();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 1;
      return 2;
   endfunction

   // half the entries stay in the same video, which keeps the other sums
   task automatic send_entry();
      send_varint(pick_groups(), ($urandom_range(0, 1) == 0) ? 0 : pick_fill());
      repeat (NUM_FIELDS - 1) send_varint(pick_groups(), pick_fill());
   endtask

   // stop sending until the block owes nothing, then let it settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (entry_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      // entry one: six-plus groups of all ones for the video, the rest small
      // entry two: video step of one wraps to zero and clears the others,
      // start time at the full 32-bit value
      static logic [7:0] short_list[20] = '{
         8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h00, 8'h7f, 8'h00,
         8'h01, 8'h01, 8'h05, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h02, 8'h03};
      int r;
      int count_sel;
      logic [COUNT_WIDTH-1:0] count;
      int entries;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // bytes before any begin and after an empty list are dropped
      send_item(ACT_BYTE, 8'h85, $urandom());
      send_item(ACT_BEGIN, 8'h00, '0);
      send_item(ACT_BYTE, 8'h00, $urandom());
      send_item(ACT_BEGIN, 8'hff, 32'd2);
      foreach (short_list[i]) send_item(ACT_BYTE, short_list[i], $urandom());
      // count used up
      send_item(ACT_BYTE, 8'hff, '1);
      drain_results();

      while (stream_items < STREAM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // noise: random items, begins with random counts now and then
            repeat ($urandom_range(1, 4))
               send_item(($urandom_range(0, 3) == 0) ? ACT_BEGIN : ACT_BYTE,
                         8'($urandom()), $urandom());
         end else begin
            count_sel = $urandom_range(0, 99);
            if (count_sel < 5) count = '0;
            else if (count_sel < 15) count = $urandom();
            else count = $urandom_range(1, 5);
            send_begin(count);
            entries = (count > 5) ? $urandom_range(1, 3) : int'(count);
            // cut the list short partway into an entry
            if (count != 0 && $urandom_range(0, 9) == 0)
               entries = $urandom_range(0, entries - 1);
            repeat (entries) send_entry();
            if (entries < count)
               repeat ($urandom_range(1, 4)) send_varint(pick_groups(), 2);
            // trailing bytes once the count is used up
            if ($urandom_range(0, 6) == 0)
               repeat ($urandom_range(1, 3))
                  send_item(ACT_BYTE, 8'($urandom()), $urandom());
            if ($urandom_range(0, 19) == 0) drain_results();
         end
      end

      drain_results();
      entry_sb.flush_leftover();
      if (entry_sb.error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/pldd_pkg.sv
rtl/pldd_core.sv
rtl/posting_list_varint_delta_decoder.sv
tb/posting_list_varint_delta_decoder_tb.sv
